// ===== hw/rtl/bpce_pkg.sv =====
package bpce_pkg;

    localparam int NUM_BREAKPOINTS = 16;
    localparam int MAX_TOKENS      = 16;
    localparam int HIT_W           = 16;
    localparam int HIT_IDX_W       = $clog2(HIT_W);
    localparam int TOK_W           = 5;
    localparam int TOK_IDX_W       = $clog2(MAX_TOKENS);
    localparam int TOK_CNT_W       = $clog2(MAX_TOKENS + 1);
    localparam int LEN_W           = 5;
    localparam int TGT_W           = 16;
    localparam int CNT_W           = 16;
    localparam int WORD_W          = 40;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 40;
    localparam int STACK_W         = MAX_TOKENS;

    localparam logic [TOK_W-1:0] TOK_AND = TOK_W'(NUM_BREAKPOINTS);
    localparam logic [TOK_W-1:0] TOK_OR  = TOK_W'(NUM_BREAKPOINTS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_TARGET   = 3'd1,
        REG_LENGTH   = 3'd2,
        REG_TOKENS_A = 3'd3,
        REG_TOKENS_B = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/bpce_ctrl.sv =====
module bpce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bpce_pkg::t_sts  i_sts,
    output bpce_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/bpce_dp.sv =====
module bpce_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [bpce_pkg::HIT_W-1:0]          i_bp_hits,
    input  bpce_pkg::t_cmd                      i_cmd,
    output bpce_pkg::t_sts                      o_sts,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_break_now,
    output logic                                o_malformed
);

    logic                                 r_enable;
    logic [bpce_pkg::TGT_W-1:0]           r_target;
    logic [bpce_pkg::LEN_W-1:0]           r_length;
    logic [2*bpce_pkg::WORD_W-1:0]        r_tokens;

    logic [bpce_pkg::HIT_W-1:0]           r_hits;
    logic [bpce_pkg::STACK_W-1:0]         r_stack;
    logic [bpce_pkg::TOK_CNT_W-1:0]       r_depth;
    logic [bpce_pkg::TOK_CNT_W-1:0]       r_idx;
    logic                                 r_bad;
    logic [bpce_pkg::CNT_W-1:0]           r_count;
    logic                                 r_out_valid;
    logic                                 r_break;
    logic                                 r_malf;

    logic [bpce_pkg::TOK_CNT_W-1:0]       len_clamped;
    logic [bpce_pkg::TOK_W-1:0]           tok;
    logic                                 hit_bit;
    logic                                 op_res;
    logic [bpce_pkg::CNT_W-1:0]           n_count;
    logic                                 fire;

    // Lengths above the token capacity behave as a full list.
    assign len_clamped = (r_length > bpce_pkg::LEN_W'(bpce_pkg::MAX_TOKENS))
                       ? bpce_pkg::TOK_CNT_W'(bpce_pkg::MAX_TOKENS)
                       : bpce_pkg::TOK_CNT_W'(r_length);

    assign tok = r_tokens[r_idx[bpce_pkg::TOK_IDX_W-1:0]*bpce_pkg::TOK_W +: bpce_pkg::TOK_W];

    assign hit_bit = (tok < bpce_pkg::TOK_W'(bpce_pkg::HIT_W))
                   ? r_hits[tok[bpce_pkg::HIT_IDX_W-1:0]] : 1'b0;

    always_comb begin
        case (tok)
            bpce_pkg::TOK_AND: op_res = r_stack[0] & r_stack[1];
            bpce_pkg::TOK_OR:  op_res = r_stack[0] | r_stack[1];
            default:           op_res = 1'b0;
        endcase
    end

    assign n_count = (r_stack[0] && (r_count != '1)) ? r_count + 1'b1 : r_count;
    assign fire    = (n_count == r_target);

    assign o_sts.done     = !r_enable || r_bad || (r_idx >= len_clamped);
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid     = r_out_valid;
    assign o_break_now = r_break;
    assign o_malformed = r_malf;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_target <= '0;
            r_length <= '0;
            r_tokens <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpce_pkg::REG_ENABLE:   r_enable <= i_cfg_data[0];
                bpce_pkg::REG_TARGET:   r_target <= i_cfg_data[bpce_pkg::TGT_W-1:0];
                bpce_pkg::REG_LENGTH:   r_length <= i_cfg_data[bpce_pkg::LEN_W-1:0];
                bpce_pkg::REG_TOKENS_A:
                    r_tokens[bpce_pkg::WORD_W-1:0] <= i_cfg_data[bpce_pkg::WORD_W-1:0];
                bpce_pkg::REG_TOKENS_B:
                    r_tokens[2*bpce_pkg::WORD_W-1:bpce_pkg::WORD_W] <=
                        i_cfg_data[bpce_pkg::WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Evaluation stack: one token per step, top of stack in bit 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_depth <= '0;
            r_bad   <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx   <= '0;
            r_depth <= '0;
            r_bad   <= (len_clamped == '0);
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (tok < bpce_pkg::TOK_W'(bpce_pkg::NUM_BREAKPOINTS)) begin
                r_depth <= r_depth + 1'b1;
            end else if (r_depth < bpce_pkg::TOK_CNT_W'(2)) begin
                r_bad <= 1'b1;
            end else begin
                r_depth <= r_depth - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hits  <= i_bp_hits;
            r_stack <= '0;
        end else if (i_cmd.step) begin
            if (tok < bpce_pkg::TOK_W'(bpce_pkg::NUM_BREAKPOINTS)) begin
                r_stack <= {r_stack[bpce_pkg::STACK_W-2:0], hit_bit};
            end else if (r_depth >= bpce_pkg::TOK_CNT_W'(2)) begin
                r_stack <= {1'b0, r_stack[bpce_pkg::STACK_W-1:2], op_res};
            end
        end
    end

    // Hit counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
            if (r_enable && !r_bad) begin
                r_count <= fire ? '0 : n_count;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_break <= r_enable && !r_bad && fire;
            r_malf  <= r_enable && r_bad;
        end
    end

endmodule

// ===== hw/rtl/breakpoint_postfix_condition_evaluator_core.sv =====
// The stack walk covers expr_length tokens (length clamped to 16) and stops early when
// the list underflows; it is skipped while disabled or for an empty list. The result is
// registered, and an item finishes only once the output register is free or being read.
// Throughput: one item at a time; the stack walk handles one token per cycle. A result
// waiting in the output register does not block acceptance of the next item, though that
// item cannot finish until the waiting result is read.
// Reset (synchronous, active low) clears the configuration, the hit counter, the output
// valid flag and the FSM.
module breakpoint_postfix_condition_evaluator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bpce_pkg::HIT_W-1:0]          i_bp_hits,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_break_now,
    output logic                                o_malformed
);

    bpce_pkg::t_cmd cmd;
    bpce_pkg::t_sts sts;

    bpce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bpce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_bp_hits   (i_bp_hits),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_break_now (o_break_now),
        .o_malformed (o_malformed)
    );

endmodule

// ===== hw/rtl/bpce_checker.sv =====
module bpce_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_break_now,
    input logic o_malformed
);

    // A result never reports a break and a malformed list together.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_break_now && o_malformed))
        else $error("break and malformed both set");

    // Once an item is taken, no second item is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted back to back");

    // A new result only appears after an evaluation that held off the input.
    a_result_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result without evaluation");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_break_now) && $stable(o_malformed)))
        else $error("stalled result changed");

endmodule

bind breakpoint_postfix_condition_evaluator_core bpce_checker u_bpce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_break_now (o_break_now),
    .o_malformed (o_malformed)
);

// ===== test/breakpoint_postfix_condition_evaluator_core_tb.sv =====
`timescale 1ns / 1ps

module breakpoint_postfix_condition_evaluator_core_tb;

    import bpce_pkg::*;

    localparam int          CYCLE_LIMIT = 5_000_000;
    localparam int          DRAIN_WAIT  = 24;
    localparam int          IDLE_PCT    = 11;
    // Operator codes above OR evaluate to false.
    localparam logic [4:0]  TOK_ZERO_LO = TOK_OR + 5'd1;
    localparam logic [4:0]  TOK_ZERO_HI = 5'd31;

    typedef struct packed {
        logic break_now;
        logic malformed;
    } t_verdict;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic [HIT_W-1:0]       i_bp_hits   = '0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic                   o_break_now;
    logic                   o_malformed;

    bit                     quiet       = 1'b0;
    int                     cycles      = 0;

    breakpoint_postfix_condition_evaluator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_bp_hits   (i_bp_hits),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_break_now (o_break_now),
        .o_malformed (o_malformed)
    );

    class verdict_scoreboard;
        logic             enable;
        logic [TGT_W-1:0] target;
        logic [LEN_W-1:0] length;
        logic [39:0]      tokens_a;
        logic [39:0]      tokens_b;
        logic [CNT_W-1:0] hit_count;
        t_verdict         expected_verdicts[$];
        int               errors;
        int               reported;

        function new();
            enable    = 1'b0;
            target    = '0;
            length    = '0;
            tokens_a  = '0;
            tokens_b  = '0;
            hit_count = '0;
            errors    = 0;
            reported  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE:   enable   = data[0];
                REG_TARGET:   target   = data[TGT_W-1:0];
                REG_LENGTH:   length   = data[LEN_W-1:0];
                REG_TOKENS_A: tokens_a = data[39:0];
                REG_TOKENS_B: tokens_b = data[39:0];
                default: ;
            endcase
        endfunction

        // Walks the postfix list for one set of hit bits and queues the verdict.
        function void note_hits(logic [HIT_W-1:0] hits);
            t_verdict    v;
            int unsigned eff_len;
            int unsigned depth;
            logic [4:0]  tok;
            logic [31:0] stack;
            logic [79:0] words;
            logic        res;
            v = '0;
            if (enable) begin
                eff_len     = (length > MAX_TOKENS) ? MAX_TOKENS : length;
                v.malformed = (eff_len == 0);
                words       = {tokens_b, tokens_a};
                stack       = '0;
                depth       = 0;
                for (int e = 0; e < eff_len && !v.malformed; e++) begin
                    tok = words[5*e +: 5];
                    if (tok < NUM_BREAKPOINTS) begin
                        stack = {stack[30:0], hits[tok]};
                        depth++;
                    end else if (depth < 2) begin
                        v.malformed = 1'b1;
                    end else begin
                        case (tok)
                            TOK_AND: res = stack[0] & stack[1];
                            TOK_OR:  res = stack[0] | stack[1];
                            default: res = 1'b0;
                        endcase
                        stack = {1'b0, stack[31:2], res};
                        depth--;
                    end
                end
                if (!v.malformed) begin
                    if (stack[0] && hit_count != '1)
                        hit_count++;
                    v.break_now = (hit_count == target);
                    if (v.break_now)
                        hit_count = '0;
                end
            end
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic break_now, logic malformed);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result: break_now=%0b malformed=%0b",
                             break_now, malformed);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (want.break_now !== break_now || want.malformed !== malformed) begin
                    errors++;
                    if (reported < 10) begin
                        reported++;
                        $display({"mismatch at %0t: expected break_now=%0b ",
                                  "malformed=%0b, got %0b %0b"},
                                 $realtime, want.break_now, want.malformed,
                                 break_now, malformed);
                    end
                end
            end
        endfunction
    endclass

    verdict_scoreboard board = new();

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_verdict(o_break_now, o_malformed);
        i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Token 0 sits in the low five bits of toks.
    task automatic apply_config(input logic en, input logic [15:0] tgt,
                                input logic [4:0] len, input logic [79:0] toks);
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_TARGET, CFG_DATA_W'(tgt));
        write_reg(REG_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_TOKENS_A, toks[39:0]);
        write_reg(REG_TOKENS_B, toks[79:40]);
        i_cfg_we <= 1'b0;
    endtask

    // With hold set, the sender waits for every pending result first.
    task automatic send_hits(input logic [HIT_W-1:0] hits, input bit hold);
        if (hold) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (board.expected_verdicts.size() != 0)
                @(posedge i_clk);
        end
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_bp_hits <= hits;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        board.note_hits(hits);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Builds a list whose first n tokens never underflow; the rest is noise.
    function automatic logic [79:0] build_expression(input int n);
        logic [79:0] toks;
        int          depth;
        int          pick;
        depth = 0;
        toks  = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            pick = $urandom_range(0, 9);
            if (i >= n) begin
                toks[5*i +: 5] = 5'($urandom_range(0, 31));
            end else if (depth >= 2 && $urandom_range(0, 1) == 1) begin
                if (pick < 5)
                    toks[5*i +: 5] = TOK_AND;
                else if (pick < 9)
                    toks[5*i +: 5] = TOK_OR;
                else
                    toks[5*i +: 5] = 5'($urandom_range(TOK_ZERO_LO, TOK_ZERO_HI));
                depth--;
            end else begin
                toks[5*i +: 5] = 5'($urandom_range(0, NUM_BREAKPOINTS - 1));
                depth++;
            end
        end
        return toks;
    endfunction

    initial begin
        logic        en;
        logic [15:0] tgt;
        logic [4:0]  len;
        logic [79:0] toks;
        int          mode;
        int          n;
        int          sel;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the block is disabled.
        send_hits(16'h0000, 1'b0);
        send_hits(16'hFFFF, 1'b0);
        settle_block();

        // Empty list.
        apply_config(1'b1, 16'd1, 5'd0, 80'd0);
        send_hits(16'hFFFF, 1'b0);
        settle_block();

        apply_config(1'b1, 16'd1, 5'd1, 80'({5'd15}));
        send_hits(16'h8000, 1'b0);
        send_hits(16'h7FFF, 1'b0);
        settle_block();

        // Target zero fires on a false condition while the count is zero.
        apply_config(1'b1, 16'd0, 5'd3, 80'({TOK_AND, 5'd1, 5'd0}));
        send_hits(16'h0000, 1'b0);
        send_hits(16'h0003, 1'b0);
        send_hits(16'h0001, 1'b0);
        settle_block();

        apply_config(1'b1, 16'd2, 5'd3, 80'({TOK_OR, 5'd9, 5'd2}));
        send_hits(16'h0004, 1'b0);
        send_hits(16'h0200, 1'b0);
        send_hits(16'h0000, 1'b0);
        settle_block();

        apply_config(1'b1, 16'd1, 5'd3, 80'({TOK_ZERO_LO, 5'd5, 5'd4}));
        send_hits(16'hFFFF, 1'b0);
        settle_block();
        apply_config(1'b1, 16'd1, 5'd3, 80'({TOK_ZERO_HI, 5'd5, 5'd4}));
        send_hits(16'hFFFF, 1'b0);
        settle_block();

        // Operators that run out of operands, at the first token and later.
        apply_config(1'b1, 16'd0, 5'd2, 80'({5'd3, TOK_AND}));
        send_hits(16'hFFFF, 1'b0);
        settle_block();
        apply_config(1'b1, 16'd0, 5'd2, 80'({TOK_OR, 5'd1}));
        send_hits(16'hFFFF, 1'b0);
        settle_block();

        // Two entries left on the stack: the top one decides.
        apply_config(1'b1, 16'd1, 5'd2, 80'({5'd5, 5'd3}));
        send_hits(16'h0020, 1'b0);
        send_hits(16'h0008, 1'b0);
        settle_block();

        // Length beyond the token count is clamped to sixteen.
        apply_config(1'b1, 16'd1, 5'd31,
                     {TOK_AND, 5'd8, 5'd7, TOK_OR, 5'd6, TOK_OR, 5'd5, TOK_OR,
                      5'd4, TOK_OR, 5'd3, TOK_OR, 5'd2, TOK_OR, 5'd1, 5'd0});
        send_hits(16'h0180, 1'b0);
        send_hits(16'h007F, 1'b0);
        settle_block();

        apply_config(1'b1, 16'hFFFF, 5'd16, {80{1'b1}});
        send_hits(16'h0001, 1'b0);
        settle_block();

        for (int p = 0; p < 9; p++) begin
            quiet = (p == 4);
            mode  = $urandom_range(0, 9);
            en    = ($urandom_range(0, 9) != 0);
            sel   = $urandom_range(0, 9);
            if (sel < 6)
                tgt = 16'($urandom_range(0, 3));
            else if (sel < 9)
                tgt = 16'($urandom_range(4, 12));
            else
                tgt = 16'($urandom);
            if (mode < 7) begin
                n    = $urandom_range(1, MAX_TOKENS);
                toks = build_expression(n);
                len  = 5'(n);
            end else if (mode == 7) begin
                toks = build_expression(MAX_TOKENS);
                len  = 5'($urandom_range(MAX_TOKENS + 1, 31));
            end else if (mode == 8) begin
                n    = $urandom_range(1, MAX_TOKENS);
                toks = build_expression(n);
                toks[5*$urandom_range(0, n - 1) +: 5] = 5'($urandom);
                len  = 5'(n);
            end else begin
                toks = {16'($urandom), $urandom, $urandom};
                len  = 5'($urandom_range(0, 31));
            end
            apply_config(en, tgt, len, toks);
            for (int k = 0; k < 100; k++)
                send_hits(16'($urandom), $urandom_range(0, 49) == 0);
            settle_block();
        end
        quiet = 1'b0;

        board.errors += board.expected_verdicts.size();
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
